@@ rtl/core/kds_pkg.sv @@
// ----------------------------------------------------------------------------
// kds_pkg
// Shared widths, codes and types of the keypad debounce scanner.
// ----------------------------------------------------------------------------
package kds_pkg;

   localparam int LEVEL_W     = 9;
   localparam int CODE_W      = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   localparam int DEF_ROWS    = 3;
   localparam int DEF_COLUMNS = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LEVEL  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_OFFSET = 8'd1;

   localparam logic              IDLE_LEVEL_RST  = 1'b1;
   localparam logic [CODE_W-1:0] CODE_OFFSET_RST = 8'd48;

   localparam logic [1:0] PH_RELEASED    = 2'd0;
   localparam logic [1:0] PH_PREPRESSED  = 2'd1;
   localparam logic [1:0] PH_PRESSED     = 2'd2;
   localparam logic [1:0] PH_PRERELEASED = 2'd3;

   typedef struct packed {
      logic held;
      logic enable;
   } kds_cell_ctl_type;

endpackage

@@ rtl/core/kds_key_cell.sv @@
// ----------------------------------------------------------------------------
// kds_key_cell
// Four-phase debounce machine of one key; flags the pre-pressed to pressed move.
// ----------------------------------------------------------------------------
module kds_key_cell
   import kds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  kds_cell_ctl_type ctl,
   output logic             press
);

   logic [1:0] phase_ff;
   logic [1:0] phase_in;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_RELEASED:    phase_in = ctl.held ? PH_PREPRESSED : PH_RELEASED;
         PH_PREPRESSED:  phase_in = ctl.held ? PH_PRESSED : PH_PRERELEASED;
         PH_PRESSED:     phase_in = ctl.held ? PH_PRESSED : PH_PRERELEASED;
         PH_PRERELEASED: phase_in = ctl.held ? PH_PREPRESSED : PH_RELEASED;
         default:        phase_in = PH_RELEASED;
      endcase
   end

   assign press = (phase_ff == PH_PREPRESSED) && ctl.held;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASED;
      end else if (ctl.enable) begin
         phase_ff <= phase_in;
      end
   end

endmodule

@@ rtl/core/kds_priority.sv @@
// ----------------------------------------------------------------------------
// kds_priority
// Pick the lowest-index press and mask updates of the keys after it.
// ----------------------------------------------------------------------------
module kds_priority
   import kds_pkg::*;
#(
   parameter int NUM_KEYS = DEF_ROWS * DEF_COLUMNS,
   parameter int IDX_W    = 4
)(
   input  logic [NUM_KEYS-1:0] press,
   output logic [NUM_KEYS-1:0] pass,
   output logic                found,
   output logic [IDX_W-1:0]    index
);

   logic [NUM_KEYS-1:0] seen;

   always_comb begin
      seen[0] = 1'b0;
      for (int i = 1; i < NUM_KEYS; i++) begin
         seen[i] = seen[i-1] | press[i-1];
      end
   end

   assign pass  = ~seen;
   assign found = |press;

   always_comb begin
      index = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (press[i]) begin
            index = IDX_W'(i);
         end
      end
   end

endmodule

@@ rtl/core/keypad_debounce_scanner_core.sv @@
// ----------------------------------------------------------------------------
// keypad_debounce_scanner_core
// Matrix keypad scanner with a four-phase debounce machine per key.
// ----------------------------------------------------------------------------
// Each req_ transfer carries one scan: one sampled level per key, bit i is
// key row*COLUMNS+column. Every scan gives exactly one rsp_ transfer:
// rsp_key_found is set when a key completed its press debounce on this
// scan, and rsp_key_code is that key index plus code_offset, modulo 256,
// else zero. The lowest such key wins; keys after it keep their phase.
// The csr_ channel writes idle_level (index 0) and code_offset (index 1);
// other indexes are dropped. Write it only while no scan is in flight.
// A scan passes an input register, then the key machines and the priority
// mask feed the result register. One scan is taken every cycle unless
// the receiver stalls; then the result register holds and one more scan
// waits in the input register, and req_ready drops until rsp_ drains.
// Synchronous reset puts every key in released, restores the register
// defaults and empties both stages.
// ----------------------------------------------------------------------------
module keypad_debounce_scanner_core
   import kds_pkg::*;
#(
   parameter int ROWS    = DEF_ROWS,
   parameter int COLUMNS = DEF_COLUMNS
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [LEVEL_W-1:0]     req_key_levels,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_key_found,
   output logic [CODE_W-1:0]      rsp_key_code,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int NUM_KEYS = ROWS * COLUMNS;
   localparam int IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   logic                idle_level_ff;
   logic [CODE_W-1:0]   code_offset_ff;
   logic                scan_valid_ff;
   logic [LEVEL_W-1:0]  scan_levels_ff;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic                rsp_found_in;
   logic [CODE_W-1:0]   rsp_code_in;

   logic                advance;
   logic [NUM_KEYS-1:0] press;
   logic [NUM_KEYS-1:0] pass;
   logic                found;
   logic [IDX_W-1:0]    index;

   assign advance   = scan_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !scan_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_level_ff  <= IDLE_LEVEL_RST;
         code_offset_ff <= CODE_OFFSET_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IDLE_LEVEL:  idle_level_ff  <= csr_data[0];
            CSR_CODE_OFFSET: code_offset_ff <= csr_data[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
      end else if (req_ready) begin
         scan_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         scan_levels_ff <= req_key_levels;
      end
   end

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      kds_cell_ctl_type ctl;
      logic             level;

      if (k < LEVEL_W) begin : g_pin
         assign level = scan_levels_ff[k];
      end else begin : g_none
         assign level = 1'b0;
      end

      assign ctl.held   = level != idle_level_ff;
      assign ctl.enable = advance && pass[k];

      kds_key_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .press (press[k])
      );
   end

   kds_priority #(
      .NUM_KEYS (NUM_KEYS),
      .IDX_W    (IDX_W)
   ) u_priority (
      .press (press),
      .pass  (pass),
      .found (found),
      .index (index)
   );

   assign rsp_found_in = found;
   assign rsp_code_in  = found ? (code_offset_ff + CODE_W'(index)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_found_ff <= rsp_found_in;
         rsp_code_ff  <= rsp_code_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_found = rsp_found_ff;
   assign rsp_key_code  = rsp_code_ff;

endmodule

@@ rtl/core/kds_checker.sv @@
// ----------------------------------------------------------------------------
// kds_checker
// Port-level checks of the keypad debounce scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kds_checker
   import kds_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_key_found,
   input logic [CODE_W-1:0]      rsp_key_code
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_code_zero_when_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_key_found) |-> (rsp_key_code == '0))
      else $error("nonzero code without a found key");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while result side is empty");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_key_found) && $stable(rsp_key_code)))
      else $error("stalled result changed");

endmodule

bind keypad_debounce_scanner_core kds_checker u_kds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_key_found (rsp_key_found),
   .rsp_key_code  (rsp_key_code)
);

@@ tb/tb_keypad_debounce_scanner_core.sv @@
// ----------------------------------------------------------------------------
// tb_keypad_debounce_scanner_core
// Self-checking bench for the keypad debounce scanner core.
// ----------------------------------------------------------------------------
// Key-matrix scans are sent over the req_ channel. A behavioral copy of the
// per-key debounce machines predicts the one result that each scan gives.
// Results are compared field by field, in order, on the rsp_ channel.
// Between phases the bench waits for every result and then rewrites
// idle_level and code_offset. Most random scans come from a slowly changing
// set of held keys, so that keys reach the pressed phase. A few scans are
// single-scan glitches. Both sides insert random idle bursts, except in the
// last phase.
// ----------------------------------------------------------------------------
module tb_keypad_debounce_scanner_core;
   import kds_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_KEYS       = DEF_ROWS * DEF_COLUMNS;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic              found;
      logic [CODE_W-1:0] code;
   } scan_result_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [LEVEL_W-1:0]     req_key_levels = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic                   rsp_key_found;
   logic [CODE_W-1:0]      rsp_key_code;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   logic [LEVEL_W-1:0] pending_scans[$];
   scan_result_type    scan_results_due[$];
   csr_write_type      csr_pending[$];

   logic [1:0]        phase_model[NUM_KEYS];
   logic              idle_model   = IDLE_LEVEL_RST;
   logic [CODE_W-1:0] offset_model = CODE_OFFSET_RST;

   bit idle_on         = 1'b1;
   int req_gap         = 0;
   int rsp_gap         = 0;
   int scans_queued    = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int quiet_cycles    = 0;

   keypad_debounce_scanner_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_levels (req_key_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_found  (rsp_key_found),
      .rsp_key_code   (rsp_key_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   // advance every key machine in index order; stop at the first new press
   function automatic void predict_scan(input logic [LEVEL_W-1:0] levels);
      scan_result_type want;
      logic            held;
      want = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (!want.found) begin
            held = (k < LEVEL_W) ? (levels[k] != idle_model) : (idle_model != 1'b0);
            case (phase_model[k])
               PH_RELEASED: begin
                  if (held) phase_model[k] = PH_PREPRESSED;
               end
               PH_PREPRESSED: begin
                  if (held) begin
                     phase_model[k] = PH_PRESSED;
                     want.found     = 1'b1;
                     want.code      = offset_model + CODE_W'(k);
                  end else begin
                     phase_model[k] = PH_PRERELEASED;
                  end
               end
               PH_PRESSED: begin
                  if (!held) phase_model[k] = PH_PRERELEASED;
               end
               default: begin
                  phase_model[k] = held ? PH_PREPRESSED : PH_RELEASED;
               end
            endcase
         end
      end
      scan_results_due.push_back(want);
   endfunction

   task automatic queue_scan(input logic [LEVEL_W-1:0] levels);
      pending_scans.push_back(levels);
      scans_queued++;
   endtask

   // held set drifts slowly; a few scans are pure glitches
   task automatic queue_random_scans(input int count);
      logic [LEVEL_W-1:0] held;
      int                 pick;
      int                 flip;
      held = '0;
      repeat (count) begin
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            queue_scan(LEVEL_W'($urandom));
         end else begin
            if (pick < 9) begin
               flip       = $urandom_range(0, LEVEL_W-1);
               held[flip] = ~held[flip];
            end else if (pick == 9) begin
               held = LEVEL_W'($urandom);
            end else if (pick == 10) begin
               held = '0;
            end
            queue_scan(held ^ {LEVEL_W{idle_model}});
         end
      end
   endtask

   task automatic wait_results_drained;
      while (results_checked != scans_queued) @(posedge clock);
   endtask

   task automatic commit_csr_writes;
      csr_write_type w;
      while (csr_pending.size() != 0) begin
         w = csr_pending.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.index;
         csr_data  <= w.data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (w.index == CSR_IDLE_LEVEL) begin
            idle_model = w.data[0];
         end else if (w.index == CSR_CODE_OFFSET) begin
            offset_model = w.data;
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] idle_data,
                               input logic [CSR_DATA_W-1:0] offset_data);
      csr_pending.push_back('{CSR_IDLE_LEVEL, idle_data});
      csr_pending.push_back('{CSR_CODE_OFFSET, offset_data});
      commit_csr_writes();
   endtask

   // scan driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_scan(req_key_levels);
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_scans.size() != 0) begin
               req_valid      <= 1'b1;
               req_key_levels <= pending_scans.pop_front();
               if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      scan_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (scan_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result transfer with no scan pending: found=%0b code=%0d",
                           $realtime, rsp_key_found, rsp_key_code);
            end else begin
               want = scan_results_due.pop_front();
               if (rsp_key_found !== want.found || rsp_key_code !== want.code) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result mismatch: expected found=%0b code=%0d, got found=%0b code=%0d",
                              $realtime, want.found, want.code, rsp_key_found, rsp_key_code);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 6) == 0) rsp_gap = $urandom_range(1, 8);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int k = 0; k < NUM_KEYS; k++) phase_model[k] = PH_RELEASED;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // default registers: all idle, all held until every key reports, release
      queue_scan('1);
      queue_scan('1);
      repeat (10) queue_scan('0);
      queue_scan('1);
      queue_scan('0);
      queue_scan('1);
      queue_scan('1);
      queue_random_scans(100);
      wait_results_drained();

      // idle low, zero offset: key 0 reports code zero
      program_regs(8'hFE, 8'h00);
      queue_scan('1);
      queue_scan('1);
      queue_scan('0);
      queue_scan('0);
      queue_random_scans(120);
      wait_results_drained();

      // idle high, offset wraps key 1 to zero; writes to unknown indexes drop
      csr_pending.push_back('{8'd2, 8'hAA});
      csr_pending.push_back('{8'hFF, 8'h55});
      commit_csr_writes();
      program_regs(8'h01, 8'hFF);
      queue_scan(9'h1FD);
      queue_scan(9'h1FD);
      queue_scan('1);
      queue_scan('1);
      queue_random_scans(120);
      wait_results_drained();

      repeat (3) begin
         program_regs(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
         queue_random_scans(110);
         wait_results_drained();
      end

      idle_on = 1'b0;
      program_regs(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      queue_random_scans(100);
      wait_results_drained();

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/kds_pkg.sv
rtl/core/kds_key_cell.sv
rtl/core/kds_priority.sv
rtl/core/keypad_debounce_scanner_core.sv
rtl/core/kds_checker.sv
tb/tb_keypad_debounce_scanner_core.sv
